// ----- sv/thd_pkg.sv -----
`timescale 1ns / 1ps

package thd_pkg;

    // Largest node count honored; larger writes are clamped to it.
    localparam int MAX_NODES   = 256;

    localparam int NODE_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int TOPO_W      = 3;
    localparam int HOP_W       = 8;
    localparam int SIDE_W      = 5;
    localparam int REM_W       = 4;
    localparam int LEVEL_W     = 4;
    localparam int RECIP_W     = 9;
    localparam int RECIP_SHIFT = 8;
    localparam int PROD_W      = NODE_W + RECIP_W;
    // ceil(sqrt(MAX_NODES))
    localparam int SIDE_MAX    = 16;

    typedef logic [TOPO_W-1:0] topo_t;

    localparam topo_t TOPO_RING     = 3'd0;
    localparam topo_t TOPO_BIRING   = 3'd1;
    localparam topo_t TOPO_MESH     = 3'd2;
    localparam topo_t TOPO_TORUS    = 3'd3;
    localparam topo_t TOPO_TREE     = 3'd4;
    localparam topo_t TOPO_CROSSBAR = 3'd5;

    typedef enum logic [0:0] {
        CFG_TOPOLOGY   = 1'b0,
        CFG_NODE_COUNT = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic [NODE_W-1:0] source_node;
        logic [NODE_W-1:0] dest_node;
    } req_t;

    typedef struct packed {
        logic [HOP_W-1:0] hop_count;
        logic             index_error;
    } rsp_t;

    typedef struct packed {
        cfg_index_t         reg_index;
        logic [COUNT_W-1:0] wdata;
    } cfg_t;

    // Load enables of the three divider stages.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // floor(256 / side); quotient estimate is then low by at most one.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [SIDE_W-1:0] side);
        logic [RECIP_W-1:0] r;
        case (side)
            5'd1:    r = 9'd256;
            5'd2:    r = 9'd128;
            5'd3:    r = 9'd85;
            5'd4:    r = 9'd64;
            5'd5:    r = 9'd51;
            5'd6:    r = 9'd42;
            5'd7:    r = 9'd36;
            5'd8:    r = 9'd32;
            5'd9:    r = 9'd28;
            5'd10:   r = 9'd25;
            5'd11:   r = 9'd23;
            5'd12:   r = 9'd21;
            5'd13:   r = 9'd19;
            5'd14:   r = 9'd18;
            5'd15:   r = 9'd17;
            5'd16:   r = 9'd16;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    // Smallest side with side*side >= n.
    function automatic logic [SIDE_W-1:0] grid_side(input logic [COUNT_W-1:0] n);
        logic [SIDE_W-1:0] side;
        side = SIDE_W'(1);
        for (int i = 1; i < SIDE_MAX; i++) begin
            if (int'(n) > i * i) begin
                side = side + 1'b1;
            end
        end
        return side;
    endfunction

    // ceil(log2 n) as the bit length of n - 1.
    function automatic logic [LEVEL_W-1:0] tree_height(input logic [COUNT_W-1:0] n);
        logic [COUNT_W-1:0] m;
        logic [LEVEL_W-1:0] h;
        m = n - 1'b1;
        h = '0;
        for (int i = 0; i < COUNT_W; i++) begin
            if (m[i]) begin
                h = LEVEL_W'(i + 1);
            end
        end
        return h;
    endfunction

    // Bit length of the xor of two indices: the first level they share.
    function automatic logic [LEVEL_W-1:0] level_of(input logic [NODE_W-1:0] x);
        logic [LEVEL_W-1:0] l;
        l = '0;
        for (int i = 0; i < NODE_W; i++) begin
            if (x[i]) begin
                l = LEVEL_W'(i + 1);
            end
        end
        return l;
    endfunction

endpackage

// ----- sv/thd_stream_if.sv -----
`timescale 1ns / 1ps

interface thd_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/thd_divmod.sv -----
`timescale 1ns / 1ps

// Three-stage split of a node index into row and column of the grid.
module thd_divmod (
    input  logic                          clk,
    input  thd_pkg::stage_en_t            adv,
    input  logic [thd_pkg::NODE_W-1:0]    value,
    input  logic [thd_pkg::SIDE_W-1:0]    side,
    input  logic [thd_pkg::RECIP_W-1:0]   recip,
    output logic [thd_pkg::NODE_W-1:0]    quo,
    output logic [thd_pkg::REM_W-1:0]     rem
);

    localparam int QMUL_W = thd_pkg::NODE_W + thd_pkg::SIDE_W;

    logic [thd_pkg::NODE_W-1:0] value1_reg;
    logic [thd_pkg::PROD_W-1:0] prod1_reg;
    logic [thd_pkg::PROD_W-1:0] prod1_next;

    logic [thd_pkg::NODE_W-1:0] q0_reg;
    logic [thd_pkg::NODE_W-1:0] q0_next;
    logic [thd_pkg::SIDE_W-1:0] rem0_reg;
    logic [thd_pkg::SIDE_W-1:0] rem0_next;
    logic [QMUL_W-1:0]          qmul;
    logic [thd_pkg::NODE_W-1:0] rem0_full;

    logic [thd_pkg::NODE_W-1:0] quo_reg;
    logic [thd_pkg::NODE_W-1:0] quo_next;
    logic [thd_pkg::REM_W-1:0]  rem_reg;
    logic [thd_pkg::REM_W-1:0]  rem_next;
    logic [thd_pkg::SIDE_W-1:0] rem_fix;
    logic                       fix;

    assign prod1_next = thd_pkg::PROD_W'(value) * thd_pkg::PROD_W'(recip);

    // estimate q0 in {q-1, q}; remainder below 2*side
    always_comb
    begin
        q0_next   = prod1_reg[thd_pkg::RECIP_SHIFT +: thd_pkg::NODE_W];
        qmul      = QMUL_W'(q0_next) * QMUL_W'(side);
        rem0_full = value1_reg - qmul[thd_pkg::NODE_W-1:0];
        rem0_next = rem0_full[thd_pkg::SIDE_W-1:0];
    end

    always_comb
    begin
        fix      = (rem0_reg >= side);
        rem_fix  = fix ? (rem0_reg - side) : rem0_reg;
        quo_next = fix ? (q0_reg + 1'b1) : q0_reg;
        rem_next = rem_fix[thd_pkg::REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s1)
        begin
            value1_reg <= value;
            prod1_reg  <= prod1_next;
        end
        if (adv.s2)
        begin
            q0_reg   <= q0_next;
            rem0_reg <= rem0_next;
        end
        if (adv.s3)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quo = quo_reg;
    assign rem = rem_reg;

endmodule

// ----- sv/topology_hop_distance_top.sv -----
`timescale 1ns / 1ps
// Pipeline: 4 register stages from item accept to result valid.
// Throughput: 1 item per cycle while hop_rsp.ready is high; the two multiplies of
//   the grid row/column split (reciprocal, then back-multiply) set the stage count.
// Reset: async active-low; clears valid bits, topology = ring, node count = 1.
// Config port is always ready; node count derived values update on the write.
module topology_hop_distance_top (
    input  logic         clk,
    input  logic         rst_n,
    thd_stream_if.sink   hop_req,
    thd_stream_if.source hop_rsp,
    thd_stream_if.sink   cfg
);

    localparam int NODE_W  = thd_pkg::NODE_W;
    localparam int COUNT_W = thd_pkg::COUNT_W;
    localparam int HOP_W   = thd_pkg::HOP_W;
    localparam int SIDE_W  = thd_pkg::SIDE_W;
    localparam int REM_W   = thd_pkg::REM_W;
    localparam int LEVEL_W = thd_pkg::LEVEL_W;

    // Per-item control carried alongside the divider stages.
    typedef struct packed {
        logic             err;
        logic             grid;
        logic             wrap;
        logic [HOP_W-1:0] early;
    } ctl_t;

    // ---------------------------------------------------------------
    // Configuration registers and values derived from node count
    // ---------------------------------------------------------------
    thd_pkg::topo_t                 topology_reg;
    logic [COUNT_W-1:0]             n_reg;
    logic [SIDE_W-1:0]              side_reg;
    logic [thd_pkg::RECIP_W-1:0]    recip_reg;
    logic [LEVEL_W-1:0]             height_reg;
    logic [COUNT_W-1:0]             n_next;
    logic [SIDE_W-1:0]              side_next;
    logic                           cfg_wr;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid && cfg.ready;

    // Clamp to MAX_NODES, then derive grid side and tree height once.
    always_comb
    begin
        n_next    = (cfg.payload.wdata > COUNT_W'(thd_pkg::MAX_NODES))
                  ? COUNT_W'(thd_pkg::MAX_NODES) : cfg.payload.wdata;
        side_next = thd_pkg::grid_side(n_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            topology_reg <= thd_pkg::TOPO_RING;
            n_reg        <= COUNT_W'(1);
            side_reg     <= SIDE_W'(1);
            recip_reg    <= thd_pkg::recip_of(SIDE_W'(1));
            height_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg.payload.reg_index)
                thd_pkg::CFG_TOPOLOGY:
                begin
                    topology_reg <= cfg.payload.wdata[thd_pkg::TOPO_W-1:0];
                end
                thd_pkg::CFG_NODE_COUNT:
                begin
                    n_reg      <= n_next;
                    side_reg   <= side_next;
                    recip_reg  <= thd_pkg::recip_of(side_next);
                    height_reg <= thd_pkg::tree_height(n_next);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Pipeline control: each stage loads when empty or draining
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    thd_pkg::stage_en_t adv;

    assign en4 = !v4_reg || hop_rsp.ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign adv.s1 = en1;
    assign adv.s2 = en2;
    assign adv.s3 = en3;

    assign hop_req.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= hop_req.valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: range check, ring / bidirectional ring / tree / crossbar
    // ---------------------------------------------------------------
    logic [NODE_W-1:0]  src;
    logic [NODE_W-1:0]  dst;
    logic [COUNT_W-1:0] ring_w;
    logic [NODE_W-1:0]  diff;
    logic [COUNT_W-1:0] back_w;
    logic [HOP_W-1:0]   bidir;
    logic [LEVEL_W-1:0] lvl;
    logic [HOP_W-1:0]   tree_hops;
    logic [HOP_W-1:0]   lvl2;
    ctl_t               ctl1_next;
    ctl_t               ctl1_reg, ctl2_reg, ctl3_reg;

    assign src = hop_req.payload.source_node;
    assign dst = hop_req.payload.dest_node;

    always_comb
    begin
        ctl1_next.err = ({1'b0, src} >= n_reg) || ({1'b0, dst} >= n_reg);

        // ring wraps forward only
        ring_w = {1'b0, dst} - {1'b0, src} + ((dst < src) ? n_reg : '0);

        diff   = (src >= dst) ? (src - dst) : (dst - src);
        back_w = n_reg - {1'b0, diff};
        bidir  = ({1'b0, diff} < back_w) ? diff : back_w[HOP_W-1:0];

        // tree: 2k, one less when the common block is the root
        lvl  = thd_pkg::level_of(src ^ dst);
        lvl2 = HOP_W'({lvl, 1'b0});
        if (n_reg <= COUNT_W'(1))
        begin
            tree_hops = '0;
        end
        else if (lvl == height_reg)
        begin
            tree_hops = lvl2 - 1'b1;
        end
        else
        begin
            tree_hops = lvl2;
        end

        ctl1_next.grid  = 1'b0;
        ctl1_next.wrap  = 1'b0;
        ctl1_next.early = '0;
        case (topology_reg)
            thd_pkg::TOPO_RING:     ctl1_next.early = ring_w[HOP_W-1:0];
            thd_pkg::TOPO_BIRING:   ctl1_next.early = bidir;
            thd_pkg::TOPO_MESH:     ctl1_next.grid  = 1'b1;
            thd_pkg::TOPO_TORUS:
            begin
                ctl1_next.grid = 1'b1;
                ctl1_next.wrap = 1'b1;
            end
            thd_pkg::TOPO_TREE:     ctl1_next.early = tree_hops;
            thd_pkg::TOPO_CROSSBAR: ctl1_next.early = HOP_W'(1);
            default:                ctl1_next.early = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            ctl1_reg <= ctl1_next;
        end
        if (en2)
        begin
            ctl2_reg <= ctl1_reg;
        end
        if (en3)
        begin
            ctl3_reg <= ctl2_reg;
        end
    end

    // ---------------------------------------------------------------
    // Stages 1-3: row/column of both nodes (row-major, side L)
    // ---------------------------------------------------------------
    logic [NODE_W-1:0] row_s, row_d;
    logic [REM_W-1:0]  col_s, col_d;

    thd_divmod u_div_src (
        .clk   (clk),
        .adv   (adv),
        .value (src),
        .side  (side_reg),
        .recip (recip_reg),
        .quo   (row_s),
        .rem   (col_s)
    );

    thd_divmod u_div_dst (
        .clk   (clk),
        .adv   (adv),
        .value (dst),
        .side  (side_reg),
        .recip (recip_reg),
        .quo   (row_d),
        .rem   (col_d)
    );

    // ---------------------------------------------------------------
    // Stage 4: Manhattan distance, torus wrap, final select
    // ---------------------------------------------------------------
    logic [HOP_W-1:0] dx, dy, dx_back, dy_back, dx_w, dy_w, side_h, grid_hops;
    thd_pkg::rsp_t    rsp_reg;
    thd_pkg::rsp_t    rsp_next;

    always_comb
    begin
        side_h  = HOP_W'(side_reg);
        dx      = (row_s >= row_d) ? (row_s - row_d) : (row_d - row_s);
        dy      = HOP_W'((col_s >= col_d) ? (col_s - col_d) : (col_d - col_s));
        dx_back = side_h - dx;
        dy_back = side_h - dy;
        dx_w    = (ctl3_reg.wrap && (dx_back < dx)) ? dx_back : dx;
        dy_w    = (ctl3_reg.wrap && (dy_back < dy)) ? dy_back : dy;
        grid_hops = dx_w + dy_w;

        rsp_next.index_error = ctl3_reg.err;
        if (ctl3_reg.err)
        begin
            rsp_next.hop_count = '0;
        end
        else if (ctl3_reg.grid)
        begin
            rsp_next.hop_count = grid_hops;
        end
        else
        begin
            rsp_next.hop_count = ctl3_reg.early;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign hop_rsp.valid   = v4_reg;
    assign hop_rsp.payload = rsp_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic req_acc, rsp_acc;
    assign req_acc = hop_req.valid && hop_req.ready;
    assign rsp_acc = hop_rsp.valid && hop_rsp.ready;

    // out-of-range item always reports zero hops
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        hop_rsp.valid && hop_rsp.payload.index_error |-> hop_rsp.payload.hop_count == '0)
        else $error("index error with nonzero hop count");

    // occupancy tracks accepts minus deliveries: nothing lost or duplicated
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones({v1_reg, v2_reg, v3_reg, v4_reg}) ==
         $countones($past({v1_reg, v2_reg, v3_reg, v4_reg}))
         + $countones($past(req_acc)) - $countones($past(rsp_acc))))
        else $error("pipeline occupancy mismatch");

    // an item held behind a stalled output stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg && !en4 |=> v3_reg)
        else $error("stalled item dropped from stage 3");

endmodule
